### hw/rtl/spg_pkg.sv
// Shared types, constants and tables of the sphere patch grid generator.
package spg_pkg;

   // Default fraction width of the Q1.F position outputs.
   localparam int FRAC_BITS_DEF = 14;

   // Long division: 16-bit magnitude shifted left by 31 gives a 47-bit dividend.
   localparam int MAG_W     = 16;
   localparam int DIV_STEPS = MAG_W + 31;
   localparam int DEN_W     = 14;
   localparam int QUO_W     = 33;

   // Rotator word widths and table.
   localparam int CORDIC_STEPS = 30;
   localparam int CW           = 34;
   localparam int ZW           = 33;
   localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;

   localparam logic [31:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
      32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
      32'd20,        32'd10,        32'd5,         32'd3,        32'd1
   };

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      CSR_GRID_LAT     = 2'd0,
      CSR_GRID_LNG     = 2'd1,
      CSR_DETAIL_LEVEL = 2'd2,
      CSR_LAT_BAND     = 2'd3
   } csr_index_type;

   // Input item.
   typedef struct packed {
      logic [7:0] grid_row;
      logic [7:0] grid_col;
   } req_type;

   // Result item.
   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic               point_ok;
      logic               quad_ok;
      logic [15:0]        tri_a0;
      logic [15:0]        tri_a1;
      logic [15:0]        tri_a2;
      logic [15:0]        tri_b0;
      logic [15:0]        tri_b1;
      logic [15:0]        tri_b2;
   } rsp_type;

   // Side band that travels with each item down the pipeline.
   typedef struct packed {
      logic       vld;
      logic       pok;
      logic       qok;
      logic [7:0] row;
      logic [7:0] col;
   } meta_type;

endpackage

### hw/rtl/sphere_patch_grid_generator_core.sv
// Top level of the sphere patch grid generator: a deep pipeline from grid point to vertex.
//
// Usage: each transfer on the req_ channel carries one grid point (row, col) of the
// latitude band selected by the csr_ registers.  Exactly one result per point leaves on
// the rsp_ channel, in order: the unit position (also the normal) in signed Q1.F, flags
// for point inside the grid and point at a quad corner, and the quad's six indices.
// The block takes one point every cycle while the output is not stalled.  Each point
// passes set-up, dividend load, the 47-stage radix-2 phase divider, phase rounding,
// rotator start, the 30-stage rotator, quadrant fix, multiply, round and output stages.
// All stages share one advance signal: when a result waits and rsp_ready is low, the
// whole pipeline holds, req_ready falls and nothing is lost or repeated.  Bubbles keep
// moving while the output slot is empty or being taken.  The user must write
// configuration only while no item is in flight; the block does not enforce it.  A write
// takes effect at once.  Synchronous reset clears every valid bit and returns the
// registers to eight by eight subdivisions, detail level one and band zero.
module sphere_patch_grid_generator_core #(
   parameter int FRAC_BITS = spg_pkg::FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  spg_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output spg_pkg::rsp_type       rsp_data,
   input  logic                   csr_we,
   input  spg_pkg::csr_index_type csr_index,
   input  logic [7:0]             csr_wdata
);
   import spg_pkg::*;

   // Stage positions.
   localparam int ST_DIV0  = 1;
   localparam int ST_PHASE = ST_DIV0 + DIV_STEPS + 1;
   localparam int ST_ROT0  = ST_PHASE + 1;
   localparam int NST      = ST_ROT0 + CORDIC_STEPS + 5;
   localparam int RW       = FRAC_BITS + 3;
   localparam int SHP      = 60 - FRAC_BITS;
   localparam int SHY      = 30 - FRAC_BITS;
   localparam logic signed [63:0] HALF_P = 64'sd1 <<< (SHP - 1);
   localparam logic signed [63:0] HALF_Y = (64'sd1 <<< SHY) >>> 1;
   localparam logic signed [RW-1:0] ONE_R = RW'(64'sd1 <<< FRAC_BITS);

   // Configuration registers.
   logic [7:0] grid_lat_ff, grid_lng_ff;
   logic [5:0] detail_level_ff;
   logic [6:0] lat_band_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_lat_ff     <= 8'd8;
         grid_lng_ff     <= 8'd8;
         detail_level_ff <= 6'd1;
         lat_band_ff     <= 7'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GRID_LAT:     grid_lat_ff     <= csr_wdata;
            CSR_GRID_LNG:     grid_lng_ff     <= csr_wdata;
            CSR_DETAIL_LEVEL: detail_level_ff <= csr_wdata[5:0];
            CSR_LAT_BAND:     lat_band_ff     <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // One advance signal for the whole pipeline.
   meta_type meta_ff [0:NST-1];
   logic     adv;

   assign adv       = !meta_ff[NST-1].vld || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = meta_ff[NST-1].vld;

   // Side band shift line.
   meta_type meta_in;

   always_comb begin
      meta_in.vld = req_valid;
      meta_in.row = req_data.grid_row;
      meta_in.col = req_data.grid_col;
      meta_in.pok = (req_data.grid_row <= grid_lat_ff) && (req_data.grid_col <= grid_lng_ff);
      meta_in.qok = (req_data.grid_row < grid_lat_ff) && (req_data.grid_col < grid_lng_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NST; i++) meta_ff[i] <= '0;
      end else if (adv) begin
         meta_ff[0] <= meta_in;
         for (int i = 1; i < NST; i++) meta_ff[i] <= meta_ff[i-1];
      end
   end

   // Set-up stage: signed latitude numerator and both denominators.
   logic [5:0]         lod_e;
   logic [7:0]         glat_e, glng_e;
   logic signed [8:0]  band_off;
   logic signed [17:0] nlat_in, nlat_ff;
   logic [DEN_W-1:0]   dlat_in, dlng_in, dlat_ff, dlng_ff;

   always_comb begin
      lod_e    = (detail_level_ff == 6'd0) ? 6'd1 : detail_level_ff;
      glat_e   = (grid_lat_ff == 8'd0) ? 8'd1 : grid_lat_ff;
      glng_e   = (grid_lng_ff == 8'd0) ? 8'd1 : grid_lng_ff;
      band_off = $signed({3'b0, lod_e}) - $signed({2'b0, lat_band_ff}) - 9'sd1;
      nlat_in  = (band_off * $signed({1'b0, glat_e}))
                 + $signed({10'b0, req_data.grid_row});
      dlat_in  = DEN_W'(lod_e) * DEN_W'(glat_e);
      dlng_in  = DEN_W'(lod_e) * DEN_W'(glng_e);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nlat_ff <= nlat_in;
         dlat_ff <= dlat_in;
         dlng_ff <= dlng_in;
      end
   end

   // Long division pipeline, lane 0 latitude and lane 1 longitude.
   logic [DIV_STEPS-1:0] dvd_ff [0:1][0:DIV_STEPS];
   logic [DEN_W-1:0]     den_ff [0:1][0:DIV_STEPS];
   logic [DEN_W-1:0]     rem_ff [0:1][0:DIV_STEPS];
   logic [QUO_W-1:0]     quo_ff [0:1][0:DIV_STEPS];
   logic                 neg_ff [0:1][0:DIV_STEPS];
   logic [MAG_W-1:0]     mag_lat;

   assign mag_lat = nlat_ff[17] ? MAG_W'(-nlat_ff) : MAG_W'(nlat_ff);

   // Dividend load: magnitude times two to the 31.
   always_ff @(posedge clock) begin
      if (adv) begin
         dvd_ff[0][0] <= {mag_lat, 31'b0};
         den_ff[0][0] <= dlat_ff;
         neg_ff[0][0] <= nlat_ff[17];
         dvd_ff[1][0] <= {8'b0, meta_ff[0].col, 31'b0};
         den_ff[1][0] <= dlng_ff;
         neg_ff[1][0] <= 1'b0;
         for (int l = 0; l < 2; l++) begin
            rem_ff[l][0] <= '0;
            quo_ff[l][0] <= '0;
         end
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_div_lane
      for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div_step
         logic [DEN_W:0]   trial;
         logic             ge;
         logic [DEN_W:0]   diff;
         logic [DEN_W-1:0] rem_in;

         // One quotient bit: shift in the next dividend bit and subtract if it fits.
         always_comb begin
            trial  = {rem_ff[l][k], dvd_ff[l][k][DIV_STEPS-1-k]};
            ge     = trial >= {1'b0, den_ff[l][k]};
            diff   = trial - {1'b0, den_ff[l][k]};
            rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               dvd_ff[l][k+1] <= dvd_ff[l][k];
               den_ff[l][k+1] <= den_ff[l][k];
               neg_ff[l][k+1] <= neg_ff[l][k];
               rem_ff[l][k+1] <= rem_in;
               quo_ff[l][k+1] <= {quo_ff[l][k][QUO_W-2:0], ge};
            end
         end
      end
   end

   // Phase: round the quotient by half and restore the sign.
   logic [31:0] ph_ff [0:1];

   for (genvar l = 0; l < 2; l++) begin : g_phase
      logic [QUO_W:0] rnd;
      logic [31:0]    ph_in;

      always_comb begin
         rnd   = {1'b0, quo_ff[l][DIV_STEPS]} + (QUO_W+1)'(1);
         ph_in = neg_ff[l][DIV_STEPS] ? (32'd0 - rnd[QUO_W-1:1]) : rnd[QUO_W-1:1];
      end

      always_ff @(posedge clock) begin
         if (adv) ph_ff[l] <= ph_in;
      end
   end

   // Rotator pipeline.
   logic signed [CW-1:0] cx_ff [0:1][0:CORDIC_STEPS];
   logic signed [CW-1:0] cy_ff [0:1][0:CORDIC_STEPS];
   logic signed [ZW-1:0] cz_ff [0:1][0:CORDIC_STEPS];
   logic [1:0]           cq_ff [0:1][0:CORDIC_STEPS];
   logic signed [CW-1:0] cos_ff [0:1];
   logic signed [CW-1:0] sin_ff [0:1];

   for (genvar l = 0; l < 2; l++) begin : g_rot_lane
      // Start vector; the top two phase bits pick the quadrant.
      always_ff @(posedge clock) begin
         if (adv) begin
            cx_ff[l][0] <= CORDIC_START;
            cy_ff[l][0] <= '0;
            cz_ff[l][0] <= $signed({3'b0, ph_ff[l][29:0]});
            cq_ff[l][0] <= ph_ff[l][31:30];
         end
      end

      for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot_step
         logic signed [CW-1:0] dx, dy, x_in, y_in;
         logic signed [ZW-1:0] at, z_in;

         always_comb begin
            dx = cy_ff[l][i] >>> i;
            dy = cx_ff[l][i] >>> i;
            at = $signed({1'b0, ATAN_TAB[i]});
            if (!cz_ff[l][i][ZW-1]) begin
               x_in = cx_ff[l][i] - dx;
               y_in = cy_ff[l][i] + dy;
               z_in = cz_ff[l][i] - at;
            end else begin
               x_in = cx_ff[l][i] + dx;
               y_in = cy_ff[l][i] - dy;
               z_in = cz_ff[l][i] + at;
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               cx_ff[l][i+1] <= x_in;
               cy_ff[l][i+1] <= y_in;
               cz_ff[l][i+1] <= z_in;
               cq_ff[l][i+1] <= cq_ff[l][i];
            end
         end
      end

      // Quadrant fix-up.
      logic signed [CW-1:0] cos_in, sin_in, xe, ye;

      always_comb begin
         xe = cx_ff[l][CORDIC_STEPS];
         ye = cy_ff[l][CORDIC_STEPS];
         case (cq_ff[l][CORDIC_STEPS])
            2'd0:    begin cos_in = xe;  sin_in = ye;  end
            2'd1:    begin cos_in = -ye; sin_in = xe;  end
            2'd2:    begin cos_in = -xe; sin_in = -ye; end
            default: begin cos_in = ye;  sin_in = -xe; end
         endcase
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cos_ff[l] <= cos_in;
            sin_ff[l] <= sin_in;
         end
      end
   end

   // Products of the latitude cosine with the longitude cosine and sine.
   logic signed [63:0] px_ff, pz_ff;
   logic signed [CW-1:0] sy_ff;
   logic signed [31:0] clat, clng, slng;

   assign clat = cos_ff[0][31:0];
   assign clng = cos_ff[1][31:0];
   assign slng = sin_ff[1][31:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff <= clat * clng;
         pz_ff <= clat * slng;
         sy_ff <= sin_ff[0];
      end
   end

   // Round half up to the output fraction width.
   logic signed [63:0]   rx_wide, ry_wide, rz_wide;
   logic signed [RW-1:0] rx_ff, ry_ff, rz_ff;

   always_comb begin
      rx_wide = (px_ff + HALF_P) >>> SHP;
      rz_wide = ((64'sd0 - pz_ff) + HALF_P) >>> SHP;
      ry_wide = (64'(sy_ff) + HALF_Y) >>> SHY;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rx_ff <= rx_wide[RW-1:0];
         ry_ff <= ry_wide[RW-1:0];
         rz_ff <= rz_wide[RW-1:0];
      end
   end

   // Output register: clamp, quad indices and masking by the grid flags.
   function automatic logic [15:0] clamp16(input logic signed [RW-1:0] v);
      logic signed [RW-1:0] c;
      logic signed [63:0]   e;
      begin
         if (v > ONE_R) c = ONE_R;
         else if (v < -ONE_R) c = -ONE_R;
         else c = v;
         e = 64'(c);
         clamp16 = e[15:0];
      end
   endfunction

   meta_type   mo;
   logic [16:0] v_idx, w_idx;
   rsp_type    rsp_in, rsp_ff;

   assign mo = meta_ff[NST-2];

   always_comb begin
      v_idx  = (17'(mo.row) * (17'(grid_lng_ff) + 17'd1)) + 17'(mo.col);
      w_idx  = v_idx + 17'(grid_lng_ff) + 17'd1;
      rsp_in = '0;
      if (mo.pok) begin
         rsp_in.pos_x    = clamp16(rx_ff);
         rsp_in.pos_y    = clamp16(ry_ff);
         rsp_in.pos_z    = clamp16(rz_ff);
         rsp_in.point_ok = 1'b1;
      end
      if (mo.qok) begin
         rsp_in.quad_ok = 1'b1;
         rsp_in.tri_a0  = v_idx[15:0];
         rsp_in.tri_a1  = w_idx[15:0];
         rsp_in.tri_a2  = v_idx[15:0] + 16'd1;
         rsp_in.tri_b0  = w_idx[15:0] + 16'd1;
         rsp_in.tri_b1  = v_idx[15:0] + 16'd1;
         rsp_in.tri_b2  = w_idx[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

`ifndef SYNTH
   // An accepted transfer enters the first stage.
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> meta_ff[0].vld)
      else $error("accepted transfer did not enter the pipeline");

   // A waiting result is held while the receiver stalls.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // A quad corner is always a grid point.
   a_quad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.quad_ok |-> rsp_data.point_ok)
      else $error("quad flagged outside the grid");

   // A point outside the grid carries no position.
   a_outside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.point_ok |->
         rsp_data.pos_x == 16'sd0 && rsp_data.pos_y == 16'sd0 && rsp_data.pos_z == 16'sd0)
      else $error("position given for a point outside the grid");
`endif

endmodule

### tb/sphere_patch_grid_generator_core_test.sv
// Self-checking regression bench for the sphere patch grid generator core.
`timescale 1ns / 100ps

// Scoreboard: predicts the vertex for each accepted grid point and checks results in order.
class vertex_scoreboard;
   spg_pkg::rsp_type pending_vertices[$];
   int unsigned mismatch_count;
   int unsigned orphan_count;
   logic [7:0] grid_lat, grid_lng;
   logic [5:0] detail_level;
   logic [6:0] lat_band;

   function new();
      reset_registers();
   endfunction

   function void reset_registers();
      grid_lat = 8'd8;
      grid_lng = 8'd8;
      detail_level = 6'd1;
      lat_band = 7'd0;
   endfunction

   function void write_register(spg_pkg::csr_index_type idx, logic [7:0] value);
      case (idx)
         spg_pkg::CSR_GRID_LAT: begin
            grid_lat = value;
         end
         spg_pkg::CSR_GRID_LNG: begin
            grid_lng = value;
         end
         spg_pkg::CSR_DETAIL_LEVEL: begin
            detail_level = value[5:0];
         end
         default: begin
            lat_band = value[6:0];
         end
      endcase
   endfunction

   // Floor shift of a signed value; >>> on a signed longint is a floor shift.
   static function longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   // Signed numerator over positive denominator, as a rounded 32-bit phase.
   static function logic [31:0] angle_to_phase(longint num, longint den);
      longint unsigned mag, quo;
      logic [31:0] p;
      mag = (num < 0) ? -num : num;
      quo = (((mag << 31) / den) + 1) >> 1;
      p = quo[31:0];
      return (num < 0) ? (32'd0 - p) : p;
   endfunction

   // Rotator: cosine and sine of a phase in Q2.30.
   static function void rotate(logic [31:0] phase, output longint c, output longint s);
      longint x, y, z, dx, dy;
      x = 652032874;
      y = 0;
      z = longint'(phase[29:0]);
      for (int i = 0; i < spg_pkg::CORDIC_STEPS; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(spg_pkg::ATAN_TAB[i]);
         end else begin
            x += dx; y -= dy; z += longint'(spg_pkg::ATAN_TAB[i]);
         end
      end
      case (phase[31:30])
         2'd0: begin c = x; s = y; end
         2'd1: begin c = -y; s = x; end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   // Round half up at bit s, then clamp to plus or minus one.
   static function logic [15:0] round_to_unit(longint v, int s);
      longint r, one;
      one = longint'(1) << spg_pkg::FRAC_BITS_DEF;
      r = (v + (longint'(1) << (s - 1))) >>> s;
      if (r > one) r = one;
      if (r < -one) r = -one;
      return r[15:0];
   endfunction

   function spg_pkg::rsp_type compute_vertex(spg_pkg::req_type pt);
      spg_pkg::rsp_type v;
      longint lod, glat, glng, nlat, clat, slat, clng, slng;
      logic [15:0] base, nxt;
      int fb;
      v = '0;
      fb = spg_pkg::FRAC_BITS_DEF;
      if (pt.grid_row > grid_lat || pt.grid_col > grid_lng) return v;
      lod = (detail_level == 0) ? 1 : detail_level;
      glat = (grid_lat == 0) ? 1 : grid_lat;
      glng = (grid_lng == 0) ? 1 : grid_lng;
      nlat = (lod - longint'(lat_band) - 1) * glat + pt.grid_row;
      rotate(angle_to_phase(nlat, lod * glat), clat, slat);
      rotate(angle_to_phase(longint'(pt.grid_col), lod * glng), clng, slng);
      v.pos_x = round_to_unit(clat * clng, 60 - fb);
      v.pos_y = round_to_unit(slat, 30 - fb);
      v.pos_z = round_to_unit(-(clat * slng), 60 - fb);
      v.point_ok = 1'b1;
      if (pt.grid_row < grid_lat && pt.grid_col < grid_lng) begin
         base = 16'(pt.grid_row * (grid_lng + 16'd1) + pt.grid_col);
         nxt = base + grid_lng + 16'd1;
         v.quad_ok = 1'b1;
         v.tri_a0 = base;
         v.tri_a1 = nxt;
         v.tri_a2 = base + 16'd1;
         v.tri_b0 = nxt + 16'd1;
         v.tri_b1 = base + 16'd1;
         v.tri_b2 = nxt;
      end
      return v;
   endfunction

   function void note_point(spg_pkg::req_type pt);
      pending_vertices.push_back(compute_vertex(pt));
   endfunction

   function void check_vertex(spg_pkg::rsp_type got);
      spg_pkg::rsp_type want;
      if (pending_vertices.size() == 0) begin
         orphan_count++;
         $display("unexpected vertex transfer: %p", got);
         return;
      end
      want = pending_vertices.pop_front();
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("vertex mismatch: expected %p, actual %p", want, got);
      end
   endfunction
endclass

module sphere_patch_grid_generator_core_test;
   localparam int LATENCY = 85;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   spg_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   spg_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   spg_pkg::csr_index_type csr_index = spg_pkg::CSR_GRID_LAT;
   logic [7:0] csr_wdata = '0;

   vertex_scoreboard board = new();
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   longint cycle_count = 0;

   sphere_patch_grid_generator_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Cycle limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sphere_patch_grid_generator_core regression: fail");
         $finish;
      end
   end

   // Result side: random back-pressure, every transfer checked.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_vertex(rsp_data);
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // One register write; the caller drops the write enable after the last one.
   task automatic write_csr(spg_pkg::csr_index_type idx, logic [7:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      board.write_register(idx, value);
      @(posedge clock);
   endtask

   task automatic set_band(int glat, int glng, int lod, int band);
      write_csr(spg_pkg::CSR_GRID_LAT, 8'(glat));
      write_csr(spg_pkg::CSR_GRID_LNG, 8'(glng));
      write_csr(spg_pkg::CSR_DETAIL_LEVEL, 8'(lod));
      write_csr(spg_pkg::CSR_LAT_BAND, 8'(band));
      csr_we <= 1'b0;
   endtask

   // One transfer on the point channel, with an optional idle gap before it.
   task automatic send_point(logic [7:0] row, logic [7:0] col);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{grid_row: row, grid_col: col};
      do @(posedge clock); while (!req_ready);
      board.note_point('{grid_row: row, grid_col: col});
   endtask

   // Stop offering points after the last accepted transfer.
   task automatic hold_input();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      hold_input();
      while (board.pending_vertices.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   // Mostly points inside the grid, some on or just beyond its edge, some anywhere.
   task automatic random_points(int count);
      int sel;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(9);
         if (sel < 7)
            send_point(8'($urandom_range(board.grid_lat)), 8'($urandom_range(board.grid_lng)));
         else if (sel < 9)
            send_point(8'(board.grid_lat + $urandom_range(1)),
                       8'(board.grid_lng + $urandom_range(1)));
         else
            send_point(8'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      send_idle_pct = 37;
      recv_idle_pct = 66;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, corners, edges and points outside the grid.
      send_point(8'd0, 8'd0);
      send_point(8'd8, 8'd8);
      send_point(8'd7, 8'd7);
      send_point(8'd8, 8'd0);
      send_point(8'd0, 8'd8);
      send_point(8'd9, 8'd0);
      send_point(8'd0, 8'd9);
      send_point(8'd255, 8'd255);
      send_point(8'haa, 8'h55);
      drain();
      // A 254 by 254 grid with the finest sphere and its last band.
      set_band(254, 254, 63, 125);
      send_point(8'd0, 8'd0);
      send_point(8'd254, 8'd254);
      send_point(8'd253, 8'd253);
      send_point(8'd255, 8'd0);
      send_point(8'd127, 8'd200);
      drain();
      // Zero subdivisions and zero detail level, band beyond the sphere.
      set_band(0, 0, 0, 127);
      send_point(8'd0, 8'd0);
      send_point(8'd1, 8'd0);
      send_point(8'd0, 8'd1);
      drain();
      set_band(1, 1, 1, 1);
      send_point(8'd0, 8'd0);
      send_point(8'd1, 8'd1);
      send_point(8'd0, 8'd1);
      drain();

      // Random phases with varied settings; a full drain between settings.
      for (int phase = 0; phase < 20; phase++) begin
         if (phase == 7) begin send_idle_pct = 66; recv_idle_pct = 37; end
         if (phase == 14) begin send_idle_pct = 0; recv_idle_pct = 0; end
         if (phase % 5 == 4)
            set_band($urandom_range(254), $urandom_range(254), $urandom_range(63),
                     $urandom_range(127));
         else
            set_band($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 8),
                     $urandom_range(15));
         random_points(50);
         // Hold the sender until every vertex in flight has come back.
         hold_input();
         while (board.pending_vertices.size() != 0) @(posedge clock);
         random_points(50);
         drain();
      end

      if (board.mismatch_count == 0 && board.orphan_count == 0 &&
          board.pending_vertices.size() == 0)
         $display("sphere_patch_grid_generator_core regression: pass");
      else
         $display("sphere_patch_grid_generator_core regression: fail");
      $finish;
   end
endmodule
